// File: rtl/core/ddn_pkg.sv
// Shared types for the DDA direction normalizer
package ddn_pkg;

    // Per-word control that rides along the divider pipeline
    typedef struct packed {
        logic zero;     // points coincide, both results are zero
        logic neg_x;    // dx is negative
        logic neg_y;    // dy is negative
        logic x_major;  // |dx| >= |dy|, x gives exactly 1.0
    } t_ctl;

endpackage

// File: rtl/core/ddn_div_stage.sv
// One restoring-division step: produces one quotient bit per stage
module ddn_div_stage #(
    parameter int RW    = 17,
    parameter int QW    = 16,
    parameter bit SHIFT = 1'b1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  ddn_pkg::t_ctl   i_ctl,
    input  logic [RW-1:0]   i_rem,
    input  logic [RW-1:0]   i_div,
    input  logic [QW-1:0]   i_quo,
    output logic            o_valid,
    output ddn_pkg::t_ctl   o_ctl,
    output logic [RW-1:0]   o_rem,
    output logic [RW-1:0]   o_div,
    output logic [QW-1:0]   o_quo
);

    logic          r_valid;
    ddn_pkg::t_ctl r_ctl;
    logic [RW-1:0] r_rem;
    logic [RW-1:0] r_div;
    logic [QW-1:0] r_quo;

    logic [RW:0]   trial;
    logic          ge;
    logic [RW-1:0] n_rem;
    logic [QW-1:0] n_quo;

    // Trial subtract; the first stage tests the integer bit without a shift
    always_comb begin
        trial = SHIFT ? {i_rem, 1'b0} : {1'b0, i_rem};
        ge    = (trial >= {1'b0, i_div});
        n_rem = ge ? RW'(trial - {1'b0, i_div}) : RW'(trial);
        n_quo = {i_quo[QW-2:0], ge};
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_ctl <= i_ctl;
        r_rem <= n_rem;
        r_div <= i_div;
        r_quo <= n_quo;
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_quo   = r_quo;

endmodule

// File: rtl/core/dda_direction_normalize.sv
// Channel  | Ports                                   | Handshake
// ---------+-----------------------------------------+----------------------------
// command  | i_target_x/y, i_origin_x/y              | taken when start && !busy
// result   | o_step_x, o_step_y                      | valid for one cycle at o_strobe
//
// One word per cycle. Stages in order: difference, magnitude compare,
// FRAC_BITS + 1 restoring-division stages, one output stage.
// Reset (synchronous, active low) clears all valid bits; busy is high while
// reset is held and clears at the first clock edge with reset released.
// Results cannot be stalled.
module dda_direction_normalize #(
    parameter int COORD_WIDTH = 16,
    parameter int FRAC_BITS   = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic signed [COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [COORD_WIDTH-1:0] i_origin_y,
    output logic                          o_strobe,
    output logic signed [FRAC_BITS+1:0]   o_step_x,
    output logic signed [FRAC_BITS+1:0]   o_step_y
);

    localparam int RW  = COORD_WIDTH + 1;  // difference / magnitude width
    localparam int QW  = FRAC_BITS + 1;    // quotient width
    localparam int OW  = FRAC_BITS + 2;    // result width
    localparam int LAT = FRAC_BITS + 4;
    localparam logic [OW-1:0] ONE = OW'(1) << FRAC_BITS;

    logic r_busy;

    // Stage A: differences
    logic                 r_a_valid;
    logic signed [RW-1:0] r_dx;
    logic signed [RW-1:0] r_dy;

    // Stage B: magnitudes and major/minor split
    logic                 r_b_valid;
    ddn_pkg::t_ctl        r_b_ctl;
    logic [RW-1:0]        r_b_major;
    logic [RW-1:0]        r_b_minor;

    logic [RW-1:0]        ax;
    logic [RW-1:0]        ay;
    ddn_pkg::t_ctl        n_b_ctl;

    // Divider chain
    logic                 v_s   [0:QW];
    ddn_pkg::t_ctl        c_s   [0:QW];
    logic [RW-1:0]        rem_s [0:QW];
    logic [RW-1:0]        div_s [0:QW];
    logic [QW-1:0]        quo_s [0:QW];

    // Output stage
    logic                 r_strobe;
    logic signed [OW-1:0] r_step_x;
    logic signed [OW-1:0] r_step_y;
    logic [OW-1:0]        minor_mag;
    logic [OW-1:0]        x_mag;
    logic [OW-1:0]        y_mag;
    logic [OW-1:0]        n_step_x;
    logic [OW-1:0]        n_step_y;

    // Busy only around reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign busy = r_busy;

    // Stage A valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= start && !r_busy;
        end
    end

    // Stage A data: differences at one extra bit, never wrap
    always_ff @(posedge i_clk) begin
        r_dx <= RW'(i_target_x) - RW'(i_origin_x);
        r_dy <= RW'(i_target_y) - RW'(i_origin_y);
    end

    // Magnitudes, signs and axis choice
    always_comb begin
        ax              = r_dx[RW-1] ? RW'(-r_dx) : RW'(r_dx);
        ay              = r_dy[RW-1] ? RW'(-r_dy) : RW'(r_dy);
        n_b_ctl.zero    = (r_dx == '0) && (r_dy == '0);
        n_b_ctl.neg_x   = r_dx[RW-1];
        n_b_ctl.neg_y   = r_dy[RW-1];
        n_b_ctl.x_major = (ax >= ay);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_ctl   <= n_b_ctl;
        r_b_major <= n_b_ctl.x_major ? ax : ay;
        r_b_minor <= n_b_ctl.x_major ? ay : ax;
    end

    // Divider: minor / major with FRAC_BITS fraction bits, one bit per stage
    assign v_s[0]   = r_b_valid;
    assign c_s[0]   = r_b_ctl;
    assign rem_s[0] = r_b_minor;
    assign div_s[0] = r_b_major;
    assign quo_s[0] = '0;

    for (genvar g = 0; g < QW; g++) begin : g_div
        ddn_div_stage #(
            .RW    (RW),
            .QW    (QW),
            .SHIFT (g != 0)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (v_s[g]),
            .i_ctl   (c_s[g]),
            .i_rem   (rem_s[g]),
            .i_div   (div_s[g]),
            .i_quo   (quo_s[g]),
            .o_valid (v_s[g+1]),
            .o_ctl   (c_s[g+1]),
            .o_rem   (rem_s[g+1]),
            .o_div   (div_s[g+1]),
            .o_quo   (quo_s[g+1])
        );
    end

    // Major axis is exactly 1.0; apply signs, zero for coincident points
    always_comb begin
        minor_mag = {1'b0, quo_s[QW]};
        x_mag     = c_s[QW].x_major ? ONE : minor_mag;
        y_mag     = c_s[QW].x_major ? minor_mag : ONE;
        n_step_x  = c_s[QW].neg_x ? OW'(-x_mag) : x_mag;
        n_step_y  = c_s[QW].neg_y ? OW'(-y_mag) : y_mag;
        if (c_s[QW].zero) begin
            n_step_x = '0;
            n_step_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= v_s[QW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_step_x <= n_step_x;
        r_step_y <= n_step_y;
    end

    assign o_strobe = r_strobe;
    assign o_step_x = r_step_x;
    assign o_step_y = r_step_y;

`ifndef SYNTHESIS
    // Every result traces back to a command taken earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, LAT))
        else $error("result without matching command");

    // At least one axis is unit length unless both are zero
    a_unit_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (OW'(o_step_x) == ONE || OW'(o_step_x) == OW'(-ONE) ||
                      OW'(o_step_y) == ONE || OW'(o_step_y) == OW'(-ONE) ||
                      (o_step_x == '0 && o_step_y == '0)))
        else $error("no unit-length axis in result");

    // Reset empties the pipeline
    a_reset_flush: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_strobe && busy)
        else $error("strobe or ready right after reset");

    // No command is taken while reset is held
    a_busy_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_a_valid)
        else $error("command taken during reset");
`endif

endmodule
